FILE: rtl/mlft_pkg.sv
// Package with the table entry type and field widths of the MAC learning table.
`timescale 1ns / 1ps
`default_nettype none
package mlft_pkg;

  localparam int unsigned SW_W   = 8;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned PORT_W = 16;

  typedef struct packed {
    logic [SW_W-1:0]   switch_id;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/mlft_if.sv
// Interfaces for the packet event channel and the forwarding decision channel.
`timescale 1ns / 1ps
`default_nettype none
interface mlft_in_if;
  logic                        valid;
  logic                        ready;
  logic [mlft_pkg::SW_W-1:0]   switch_id;
  logic [mlft_pkg::MAC_W-1:0]  src_mac;
  logic [mlft_pkg::MAC_W-1:0]  dst_mac;
  logic [mlft_pkg::PORT_W-1:0] in_port;

  modport source (output valid, switch_id, src_mac, dst_mac, in_port, input ready);
  modport sink (input valid, switch_id, src_mac, dst_mac, in_port, output ready);
endinterface

interface mlft_out_if;
  logic                        valid;
  logic                        ready;
  logic                        forward;
  logic [mlft_pkg::PORT_W-1:0] out_port;
  logic                        learn_dropped;

  modport source (output valid, forward, out_port, learn_dropped, input ready);
  modport sink (input valid, forward, out_port, learn_dropped, output ready);
endinterface
`default_nettype wire

FILE: rtl/mlft_table.sv
// Single-port-write, registered-read memory that holds the learned entries.
`timescale 1ns / 1ps
`default_nettype none
module mlft_table #(
  parameter int unsigned DEPTH = 256
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire mlft_pkg::entry_t        wr_data,
  input  wire                          rd_en,
  input  wire [$clog2(DEPTH)-1:0]      rd_addr,
  output mlft_pkg::entry_t             rd_data
);

  mlft_pkg::entry_t mem [DEPTH];
  mlft_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/mac_learning_forward_table_core.sv
// Top level of the MAC learning switch table with its scan sequencer.
//
//  Channel  Direction  Word
//  in_chan  sink       switch_id, src_mac, dst_mac, in_port
//  out_chan source     forward, out_port, learn_dropped
//
// Each word is handled by a scan that reads one table entry per cycle, up to
// the fill count, and checks source and destination.
// Reset clears the fill count and the sequencer; entries need no clearing.
// The result waits in an output register, so a new word is taken while it stalls.
// A word is not accepted while a scan is running.
`timescale 1ns / 1ps
`default_nettype none
module mac_learning_forward_table_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input wire         clk,
  input wire         rst_n,
  mlft_in_if.sink    in_chan,
  mlft_out_if.source out_chan
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        src_found_r, src_found_nxt;
  logic                        dst_hit_r, dst_hit_nxt;
  logic [mlft_pkg::PORT_W-1:0] dst_port_r, dst_port_nxt;
  logic [mlft_pkg::SW_W-1:0]   sw_r;
  logic [mlft_pkg::MAC_W-1:0]  src_r;
  logic [mlft_pkg::MAC_W-1:0]  dst_r;
  logic [mlft_pkg::PORT_W-1:0] port_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_fwd_r;
  logic [mlft_pkg::PORT_W-1:0] out_port_r;
  logic                        out_drop_r;

  logic             accept;
  logic             rd_en;
  logic             wr_en;
  logic             full;
  logic             learn;
  logic             fire;
  logic             self_hit;
  logic             match_src;
  logic             match_dst;
  mlft_pkg::entry_t rd_data;
  mlft_pkg::entry_t wr_data;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (fill_r == CW'(TABLE_DEPTH));
  assign learn         = !src_found_r && !full;
  assign fire          = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);
  assign self_hit      = learn && (dst_r == src_r);
  assign rd_en         = (state_r == ST_SCAN) && (cnt_r < fill_r);
  assign wr_en         = fire && learn;
  assign match_src     = (rd_data.switch_id == sw_r) && (rd_data.mac == src_r);
  assign match_dst     = (rd_data.switch_id == sw_r) && (rd_data.mac == dst_r);

  always_comb begin
    wr_data.switch_id = sw_r;
    wr_data.mac       = src_r;
    wr_data.port      = port_r;
  end

  mlft_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[IW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = rd_en;
    src_found_nxt = src_found_r;
    dst_hit_nxt   = dst_hit_r;
    dst_port_nxt  = dst_port_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_SCAN;
          cnt_nxt       = '0;
          src_found_nxt = 1'b0;
          dst_hit_nxt   = 1'b0;
          dst_port_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (match_src) begin
            src_found_nxt = 1'b1;
          end
          if (match_dst && !dst_hit_r) begin
            dst_hit_nxt  = 1'b1;
            dst_port_nxt = rd_data.port;
          end
        end else if (!rd_en) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (learn) begin
            fill_nxt = fill_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    src_found_r <= src_found_nxt;
    dst_hit_r   <= dst_hit_nxt;
    dst_port_r  <= dst_port_nxt;
    if (accept) begin
      sw_r   <= in_chan.switch_id;
      src_r  <= in_chan.src_mac;
      dst_r  <= in_chan.dst_mac;
      port_r <= in_chan.in_port;
    end
    if (fire) begin
      out_fwd_r  <= dst_hit_r || self_hit;
      out_port_r <= dst_hit_r ? dst_port_r : (self_hit ? port_r : '0);
      out_drop_r <= !src_found_r && full;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.forward       = out_fwd_r;
  assign out_chan.out_port      = out_port_r;
  assign out_chan.learn_dropped = out_drop_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (fill_r != $past(fill_r)) |-> fill_r == $past(fill_r) + CW'(1))
    else $error("fill count moved by other than one");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the finish step");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !src_found_r && !full |=> fill_r == $past(fill_r) + CW'(1))
    else $error("new source not learned while table had room");

endmodule
`default_nettype wire
